/* rtl/core/tes_pkg.sv */
// Shared types and constants for the text encoding sniffer.
package tes_pkg;

  // Result codes
  typedef enum logic [3:0] {
    ENC_ASCII     = 4'd0,
    ENC_BINARY    = 4'd1,
    ENC_U16LE     = 4'd2,
    ENC_U16LE_BOM = 4'd3,
    ENC_U16BE     = 4'd4,
    ENC_U16BE_BOM = 4'd5,
    ENC_U32LE     = 4'd6,
    ENC_U32BE     = 4'd7,
    ENC_U8        = 4'd8,
    ENC_U8_BOM    = 4'd9
  } encoding_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_BUFFER_LENGTH = 1'b0,
    CFG_PREFER_UTF8   = 1'b1
  } cfg_index_e;

  localparam int unsigned CfgDataWidth = 31;

  // Byte-order marks as they appear in the head word (first byte in bits 7:0)
  localparam logic [31:0] Bom32Le   = 32'h0000_FEFF;
  localparam logic [31:0] Bom32Be   = 32'hFFFE_0000;
  localparam logic [15:0] Bom16Le   = 16'hFEFF;
  localparam logic [15:0] Bom16Be   = 16'hFFFE;
  localparam logic [15:0] Bom8Low   = 16'hBBEF;
  localparam logic [7:0]  Bom8High  = 8'hBF;

  // UTF-8 lead byte limits
  localparam logic [7:0]  Lead2Max  = 8'hC1;
  localparam logic [7:0]  Lead4Min  = 8'hF5;

  // Null density divisor: UTF-16 once nulls exceed length / NullRatio
  localparam int unsigned NullRatio = 50;

endpackage

/* rtl/core/text_encoding_sniffer.sv */
// Streaming text encoding classifier: one byte per cycle when not stalled, one verdict per buffer.
//
// Usage: program buffer_length (index 0) and prefer_utf8 (index 1) through the
// write port, then stream the buffer's bytes in address order on the input
// channel (in_valid_i / in_stall_o / data_byte_i). After the last byte of each
// buffer one transaction with the verdict appears on the output channel
// (out_valid_o / out_stall_i / encoding_o); all other bytes give none.
// The last byte passes through the input register, and its verdict is then loaded
// into the result register, which holds it until the receiver takes it; the verdict
// is loaded only while the result register is free.
// Throughput: one byte per cycle while in_stall_o is low; the byte update is a
// handful of small compares plus one LENGTH_BITS+6 bit add and compare for the null threshold.
// When the receiver stalls, the result register holds its transaction; the
// input keeps flowing until a second verdict is ready, then in_stall_o rises
// until the held result is taken.
// Reset: buffer_length returns to 1, prefer_utf8 to 0, and all scan state and
// both pipeline valid bits are cleared; the block takes bytes as soon as reset
// is released. A finished verdict also clears the scan state, so the
// next byte starts a new buffer.
module text_encoding_sniffer #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [tes_pkg::CfgDataWidth-1:0] cfg_data_i,
  // input byte channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  // verdict channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       encoding_o
);

  localparam int unsigned NullW = LENGTH_BITS + 6;
  localparam logic [NullW-1:0] NullStep = NullW'(tes_pkg::NullRatio);

  // Configuration registers
  logic [LENGTH_BITS-1:0] buffer_length_q;
  logic                   prefer_utf8_q;

  // Input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // Result stage
  logic                out_valid_q;
  tes_pkg::encoding_e  out_enc_q;

  // Scan state; nulls are kept pre-multiplied by the ratio
  logic [LENGTH_BITS-1:0] bytes_seen_q, bytes_seen_d;
  logic                   word_all_zero_q, word_all_zero_d;
  logic                   binary_seen_q, binary_seen_d;
  logic [31:0]            head_bytes_q, head_bytes_d;
  logic [NullW-1:0]       null_x50_q, null_x50_d;
  logic [1:0]             pending_q, pending_d;
  logic                   high_bit_q, high_bit_d;
  logic                   scan_done_q, scan_done_d;
  tes_pkg::encoding_e     scan_verdict_q, scan_verdict_d;

  logic [LENGTH_BITS-1:0] len_eff;
  logic [LENGTH_BITS:0]   n_count;
  logic                   last_byte;
  logic                   out_free;
  logic                   s1_fire;
  logic [NullW-1:0]       null_x50_inc;
  logic                   null_hit;
  tes_pkg::encoding_e     verdict;

  // Handshake: the result register parts the two sides
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && (!last_byte || out_free);
  assign in_stall_o  = s1_valid_q && !s1_fire;
  assign out_valid_o = out_valid_q;
  assign encoding_o  = out_enc_q;

  // Length of zero acts as one
  assign len_eff   = (buffer_length_q == '0) ? LENGTH_BITS'(1) : buffer_length_q;
  assign n_count   = {1'b0, bytes_seen_q} + (LENGTH_BITS + 1)'(1);
  assign last_byte = (n_count >= {1'b0, len_eff});

  // nulls > floor(len/50)  <=>  len < 50 * nulls
  assign null_x50_inc = null_x50_q + NullStep;
  assign null_hit     = ({6'b0, len_eff} < null_x50_inc);

  // Per-byte state update
  always_comb begin
    bytes_seen_d    = n_count[LENGTH_BITS-1:0];
    head_bytes_d    = head_bytes_q;
    word_all_zero_d = word_all_zero_q && (s1_byte_q == 8'h00);
    binary_seen_d   = binary_seen_q;
    null_x50_d      = null_x50_q;
    pending_d       = pending_q;
    high_bit_d      = high_bit_q;
    scan_done_d     = scan_done_q;
    scan_verdict_d  = scan_verdict_q;

    // capture the first four bytes
    if (bytes_seen_q[LENGTH_BITS-1:2] == '0) begin
      case (bytes_seen_q[1:0])
        2'd0:    head_bytes_d[7:0]   = s1_byte_q;
        2'd1:    head_bytes_d[15:8]  = s1_byte_q;
        2'd2:    head_bytes_d[23:16] = s1_byte_q;
        default: head_bytes_d[31:24] = s1_byte_q;
      endcase
    end

    // aligned all-zero word check
    if (bytes_seen_q[1:0] == 2'd3) begin
      binary_seen_d   = binary_seen_q || word_all_zero_d;
      word_all_zero_d = 1'b1;
    end

    // UTF-16 / UTF-8 scan until the first verdict latches
    if (!scan_done_q) begin
      if (s1_byte_q == 8'h00) begin
        null_x50_d = null_x50_inc;
        if (null_hit) begin
          scan_done_d    = 1'b1;
          scan_verdict_d = bytes_seen_q[0] ? tes_pkg::ENC_U16LE : tes_pkg::ENC_U16BE;
        end else begin
          pending_d = 2'd0;
        end
      end else if (!s1_byte_q[7]) begin
        if (pending_q != 2'd0) begin
          scan_done_d    = 1'b1;
          scan_verdict_d = tes_pkg::ENC_ASCII;
        end
      end else begin
        high_bit_d = 1'b1;
        if (!s1_byte_q[6]) begin
          // continuation byte
          if (pending_q == 2'd0) begin
            scan_done_d    = 1'b1;
            scan_verdict_d = tes_pkg::ENC_ASCII;
          end else begin
            pending_d = pending_q - 2'd1;
          end
        end else if (pending_q != 2'd0) begin
          scan_done_d    = 1'b1;
          scan_verdict_d = tes_pkg::ENC_ASCII;
        end else if (!s1_byte_q[5]) begin
          if (s1_byte_q <= tes_pkg::Lead2Max) begin
            scan_done_d    = 1'b1;
            scan_verdict_d = tes_pkg::ENC_ASCII;
          end else begin
            pending_d = 2'd1;
          end
        end else if (!s1_byte_q[4]) begin
          pending_d = 2'd2;
        end else if (!s1_byte_q[3]) begin
          if (s1_byte_q >= tes_pkg::Lead4Min) begin
            scan_done_d    = 1'b1;
            scan_verdict_d = tes_pkg::ENC_ASCII;
          end else begin
            pending_d = 2'd3;
          end
        end else begin
          scan_done_d    = 1'b1;
          scan_verdict_d = tes_pkg::ENC_ASCII;
        end
      end
    end
  end

  // Final verdict from the updated state, in priority order
  always_comb begin
    if (n_count < (LENGTH_BITS + 1)'(2)) begin
      verdict = tes_pkg::ENC_ASCII;
    end else if (binary_seen_d) begin
      verdict = tes_pkg::ENC_BINARY;
    end else if (n_count >= (LENGTH_BITS + 1)'(4) && head_bytes_d == tes_pkg::Bom32Le) begin
      verdict = tes_pkg::ENC_U32LE;
    end else if (n_count >= (LENGTH_BITS + 1)'(4) && head_bytes_d == tes_pkg::Bom32Be) begin
      verdict = tes_pkg::ENC_U32BE;
    end else if (head_bytes_d[15:0] == tes_pkg::Bom16Le) begin
      verdict = tes_pkg::ENC_U16LE_BOM;
    end else if (head_bytes_d[15:0] == tes_pkg::Bom16Be) begin
      verdict = tes_pkg::ENC_U16BE_BOM;
    end else if (n_count < (LENGTH_BITS + 1)'(3)) begin
      verdict = tes_pkg::ENC_ASCII;
    end else if (head_bytes_d[15:0] == tes_pkg::Bom8Low &&
                 head_bytes_d[23:16] == tes_pkg::Bom8High) begin
      verdict = tes_pkg::ENC_U8_BOM;
    end else if (scan_done_d) begin
      verdict = scan_verdict_d;
    end else if (high_bit_d && pending_d == 2'd0) begin
      verdict = tes_pkg::ENC_U8;
    end else if (!high_bit_d && prefer_utf8_q) begin
      verdict = tes_pkg::ENC_U8;
    end else begin
      verdict = tes_pkg::ENC_ASCII;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_length_q <= LENGTH_BITS'(1);
      prefer_utf8_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tes_pkg::CFG_BUFFER_LENGTH: buffer_length_q <= cfg_data_i[LENGTH_BITS-1:0];
        tes_pkg::CFG_PREFER_UTF8:   prefer_utf8_q   <= cfg_data_i[0];
        default:                    prefer_utf8_q   <= prefer_utf8_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= data_byte_i;
    end
  end

  // Scan state registers; cleared after each verdict
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q    <= '0;
      word_all_zero_q <= 1'b1;
      binary_seen_q   <= 1'b0;
      head_bytes_q    <= '0;
      null_x50_q      <= '0;
      pending_q       <= 2'd0;
      high_bit_q      <= 1'b0;
      scan_done_q     <= 1'b0;
      scan_verdict_q  <= tes_pkg::ENC_ASCII;
    end else if (s1_fire) begin
      if (last_byte) begin
        bytes_seen_q    <= '0;
        word_all_zero_q <= 1'b1;
        binary_seen_q   <= 1'b0;
        head_bytes_q    <= '0;
        null_x50_q      <= '0;
        pending_q       <= 2'd0;
        high_bit_q      <= 1'b0;
        scan_done_q     <= 1'b0;
        scan_verdict_q  <= tes_pkg::ENC_ASCII;
      end else begin
        bytes_seen_q    <= bytes_seen_d;
        word_all_zero_q <= word_all_zero_d;
        binary_seen_q   <= binary_seen_d;
        head_bytes_q    <= head_bytes_d;
        null_x50_q      <= null_x50_d;
        pending_q       <= pending_d;
        high_bit_q      <= high_bit_d;
        scan_done_q     <= scan_done_d;
        scan_verdict_q  <= scan_verdict_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_fire && last_byte) begin
      out_enc_q <= verdict;
    end
  end

`ifndef SYNTH
  // Input only backs up behind a held, stalled verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a blocked verdict");

  // A verdict restarts the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && last_byte) |=> (bytes_seen_q == '0 && null_x50_q == '0))
    else $error("scan state not cleared after verdict");

  // No scan verdict without the latch flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_done_q |-> (scan_verdict_q == tes_pkg::ENC_ASCII))
    else $error("scan verdict set without scan_done");

  // Fresh buffer carries no history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_seen_q == '0) |-> (head_bytes_q == '0 && !high_bit_q && !binary_seen_q))
    else $error("stale state at start of buffer");
`endif

endmodule
